[rtl/core/nsos_pkg.sv]
package nsos_pkg;

   // Configuration port geometry: five registers at 8-byte spacing.
   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;

   // Width of the forward match counter, which saturates at its top value.
   localparam int FWD_CNT_W = 5;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] match_start;
   } rsp_type;

   typedef struct packed {
      logic [63:0] pattern_bytes;
      logic [3:0]  pattern_length;
      logic [4:0]  occurrence;
      logic [16:0] scan_limit;
      logic        direction;
   } cfg_type;

   typedef enum logic [2:0] {
      REG_PATTERN_BYTES  = 3'd0,
      REG_PATTERN_LENGTH = 3'd1,
      REG_OCCURRENCE     = 3'd2,
      REG_SCAN_LIMIT     = 3'd3,
      REG_DIRECTION      = 3'd4
   } reg_index_type;

   // Control handed from the scan stage to the result stage.
   typedef struct packed {
      logic valid;
      logic direction;
      logic fwd_found;
      logic ring_ok;
   } fin_type;

endpackage

[rtl/core/nsos_csr.sv]
module nsos_csr
   import nsos_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          wr_en;

   assign reg_index = reg_index_type'(paddr[CSR_AW-1:3]);
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_PATTERN_BYTES:  cfg_in.pattern_bytes  = pwdata;
            REG_PATTERN_LENGTH: cfg_in.pattern_length = pwdata[3:0];
            REG_OCCURRENCE:     cfg_in.occurrence     = pwdata[4:0];
            REG_SCAN_LIMIT:     cfg_in.scan_limit     = pwdata[16:0];
            REG_DIRECTION:      cfg_in.direction      = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_PATTERN_BYTES:  prdata = cfg_ff.pattern_bytes;
         REG_PATTERN_LENGTH: prdata = CSR_DW'(cfg_ff.pattern_length);
         REG_OCCURRENCE:     prdata = CSR_DW'(cfg_ff.occurrence);
         REG_SCAN_LIMIT:     prdata = CSR_DW'(cfg_ff.scan_limit);
         REG_DIRECTION:      prdata = CSR_DW'(cfg_ff.direction);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_bytes  <= '0;
         cfg_ff.pattern_length <= 4'd1;
         cfg_ff.occurrence     <= 5'd1;
         cfg_ff.scan_limit     <= 17'h10000;
         cfg_ff.direction      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/nsos_scan.sv]
module nsos_scan
   import nsos_pkg::*;
#(
   parameter int MAX_PATTERN    = 8,
   parameter int MAX_TEXT       = 65536,
   parameter int MAX_OCCURRENCE = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  req_type                     req_data,
   input  cfg_type                     cfg,
   input  logic                        fin_take,
   output fin_type                     fin,
   output logic [$clog2(MAX_TEXT)-1:0] fin_end,
   output logic [$clog2(MAX_TEXT)-1:0] fin_pos,
   output logic [$clog2(MAX_TEXT)-1:0] fin_fwd_start,
   output logic [3:0]                  fin_plen
);

   localparam int PW = $clog2(MAX_TEXT);
   localparam int RW = (MAX_OCCURRENCE > 1) ? $clog2(MAX_OCCURRENCE) : 1;
   localparam int FW = $clog2(MAX_OCCURRENCE + 1);
   localparam int HW = (MAX_PATTERN > 1) ? (MAX_PATTERN - 1) * 8 : 8;
   localparam int WW = MAX_PATTERN * 8;
   localparam int CW = ((PW > 17) ? PW : 17) + 1;
   localparam int AW = ((RW > 5) ? RW : 5) + 1;

   // Input register.
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;

   // Per-text state.
   logic [HW-1:0]        hist_ff, hist_in;
   logic [PW-1:0]        pos_ff, pos_in;
   logic [FWD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 fwd_valid_ff, fwd_valid_in;
   logic [PW-1:0]        fwd_pos_ff, fwd_pos_in;
   logic [RW-1:0]        wp_ff, wp_in;
   logic [FW-1:0]        fill_ff, fill_in;

   // Ring of recent match end positions; read once per text.
   logic [PW-1:0] ring_mem [MAX_OCCURRENCE];
   logic [PW-1:0] rdata_ff;

   // Second stage, holding a finished text until the result stage takes it.
   logic          s2_valid_ff, s2_valid_in;
   logic          s2_dir_ff;
   logic          s2_fwd_found_ff;
   logic          s2_ring_ok_ff;
   logic          s2_bypass_ff;
   logic [PW-1:0] s2_pos_ff;
   logic [PW-1:0] s2_fwd_start_ff;
   logic [3:0]    s2_plen_ff;

   logic          s1_go, s1_fin, s2_free;
   logic [3:0]    plen_eff;
   logic [WW-1:0] window;
   logic          win_ok, long_enough, hit;
   logic [PW-1:0] fwd_s;
   logic          fwd_in_limit, occ_ok;
   logic [RW-1:0] wp_next;
   logic [FW-1:0] fill_next;
   logic [AW-1:0] rd_a, rd_o, rd_d;
   logic [RW-1:0] rd_idx;
   logic          ring_ok;

   assign s2_free   = !s2_valid_ff || fin_take;
   assign s1_go     = s1_valid_ff && (!s1_data_ff.last_byte || s2_free);
   assign s1_fin    = s1_go && s1_data_ff.last_byte;
   assign req_ready = !s1_valid_ff || s1_go;

   always_comb begin
      if (cfg.pattern_length == 4'd0) begin
         plen_eff = 4'd1;
      end else if (int'(cfg.pattern_length) > MAX_PATTERN) begin
         plen_eff = 4'(MAX_PATTERN);
      end else begin
         plen_eff = cfg.pattern_length;
      end
   end

   // The current byte sits in the low byte of the window.
   assign window = WW'({hist_ff, s1_data_ff.text_byte});

   // Pattern byte k lines up with window byte plen-1-k.
   always_comb begin
      win_ok = 1'b1;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if (k < int'(plen_eff)) begin
            if (window[8 * (int'(plen_eff) - 1 - k) +: 8] != cfg.pattern_bytes[8 * k +: 8]) begin
               win_ok = 1'b0;
            end
         end
      end
   end

   assign long_enough  = (CW'(pos_ff) + CW'(1)) >= CW'(plen_eff);
   assign hit          = win_ok && long_enough;
   assign fwd_s        = pos_ff + PW'(1) - PW'(plen_eff);
   assign fwd_in_limit = CW'(fwd_s) < CW'(cfg.scan_limit);
   assign occ_ok       = (cfg.occurrence != 5'd0) && (int'(cfg.occurrence) <= MAX_OCCURRENCE);

   always_comb begin
      cnt_in       = cnt_ff;
      fwd_valid_in = fwd_valid_ff;
      fwd_pos_in   = fwd_pos_ff;
      if (hit && fwd_in_limit && !fwd_valid_ff) begin
         if (cnt_ff != {FWD_CNT_W{1'b1}}) begin
            cnt_in = cnt_ff + FWD_CNT_W'(1);
         end
         if (occ_ok && cnt_in == cfg.occurrence) begin
            fwd_valid_in = 1'b1;
            fwd_pos_in   = fwd_s;
         end
      end
   end

   always_comb begin
      wp_next   = wp_ff;
      fill_next = fill_ff;
      if (hit) begin
         wp_next = (int'(wp_ff) == MAX_OCCURRENCE - 1) ? '0 : wp_ff + RW'(1);
         if (int'(fill_ff) < MAX_OCCURRENCE) begin
            fill_next = fill_ff + FW'(1);
         end
      end
   end

   // Slot of the requested match, counted back from the newest one.
   assign rd_a    = AW'(wp_next);
   assign rd_o    = AW'(cfg.occurrence);
   assign rd_d    = (rd_a >= rd_o) ? rd_a - rd_o : rd_a + AW'(MAX_OCCURRENCE) - rd_o;
   assign rd_idx  = RW'(rd_d);
   assign ring_ok = occ_ok && (AW'(fill_next) >= rd_o);

   always_comb begin
      hist_in = hist_ff;
      if (MAX_PATTERN > 1) begin
         hist_in = HW'(window);
      end
   end

   assign pos_in = (int'(pos_ff) == MAX_TEXT - 1) ? '0 : pos_ff + PW'(1);

   assign s1_valid_in = (req_valid && req_ready) ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = s1_fin ? 1'b1 : (fin_take ? 1'b0 : s2_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         hist_ff      <= '0;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         fwd_valid_ff <= 1'b0;
         fwd_pos_ff   <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (s1_fin) begin
            hist_ff      <= '0;
            pos_ff       <= '0;
            cnt_ff       <= '0;
            fwd_valid_ff <= 1'b0;
            fwd_pos_ff   <= '0;
            wp_ff        <= '0;
            fill_ff      <= '0;
         end else if (s1_go) begin
            hist_ff      <= hist_in;
            pos_ff       <= pos_in;
            cnt_ff       <= cnt_in;
            fwd_valid_ff <= fwd_valid_in;
            fwd_pos_ff   <= fwd_pos_in;
            wp_ff        <= wp_next;
            fill_ff      <= fill_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (s1_fin) begin
         s2_dir_ff       <= cfg.direction;
         s2_fwd_found_ff <= fwd_valid_in;
         s2_fwd_start_ff <= fwd_pos_in;
         s2_ring_ok_ff   <= ring_ok;
         s2_bypass_ff    <= hit && (cfg.occurrence == 5'd1);
         s2_pos_ff       <= pos_ff;
         s2_plen_ff      <= plen_eff;
      end
   end

   // The first occurrence from the end, when the last byte itself completes a
   // match, is the slot written at this same edge, so it is taken from s2_pos_ff.
   always_ff @(posedge clock) begin
      if (s1_go && hit) begin
         ring_mem[wp_ff] <= pos_ff;
      end
      if (s1_fin) begin
         rdata_ff <= ring_mem[rd_idx];
      end
   end

   assign fin.valid     = s2_valid_ff;
   assign fin.direction = s2_dir_ff;
   assign fin.fwd_found = s2_fwd_found_ff;
   assign fin.ring_ok   = s2_ring_ok_ff;
   assign fin_end       = s2_bypass_ff ? s2_pos_ff : rdata_ff;
   assign fin_pos       = s2_pos_ff;
   assign fin_fwd_start = s2_fwd_start_ff;
   assign fin_plen      = s2_plen_ff;

   fill_bound_a: assert property (@(posedge clock) disable iff (reset)
      int'(fill_ff) <= MAX_OCCURRENCE)
      else $error("ring fill count beyond ring depth");

   ring_pointer_a: assert property (@(posedge clock) disable iff (reset)
      (int'(fill_ff) < MAX_OCCURRENCE) |-> (FW'(wp_ff) == fill_ff))
      else $error("ring write pointer out of step with fill count");

   text_clear_a: assert property (@(posedge clock) disable iff (reset)
      s1_fin |=> (fill_ff == '0 && pos_ff == '0 && !fwd_valid_ff && cnt_ff == '0))
      else $error("per-text state not cleared after the last word");

endmodule

[rtl/core/nsos_resolve.sv]
module nsos_resolve
   import nsos_pkg::*;
#(
   parameter int MAX_TEXT = 65536
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fin_type                     fin,
   input  logic [$clog2(MAX_TEXT)-1:0] fin_end,
   input  logic [$clog2(MAX_TEXT)-1:0] fin_pos,
   input  logic [$clog2(MAX_TEXT)-1:0] fin_fwd_start,
   input  logic [3:0]                  fin_plen,
   input  logic [16:0]                 scan_limit,
   output logic                        fin_take,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output rsp_type                     rsp_data
);

   localparam int PW = $clog2(MAX_TEXT);
   localparam int CW = ((PW > 17) ? PW : 17) + 1;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   logic          rev_found;
   logic [PW-1:0] rev_start;

   assign fin_take = !rsp_valid_ff || rsp_ready;

   // A match counts from the end when its last byte lies after total - limit.
   assign rev_found = fin.ring_ok &&
                      ((CW'(fin_end) + CW'(scan_limit)) > (CW'(fin_pos) + CW'(1)));
   assign rev_start = fin_end + PW'(1) - PW'(fin_plen);

   always_comb begin
      rsp_data_in = '0;
      if (fin.direction) begin
         if (rev_found) begin
            rsp_data_in.found       = 1'b1;
            rsp_data_in.match_start = 16'(rev_start);
         end
      end else if (fin.fwd_found) begin
         rsp_data_in.found       = 1'b1;
         rsp_data_in.match_start = 16'(fin_fwd_start);
      end
   end

   assign rsp_valid_in = (fin.valid && fin_take) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin.valid && fin_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   not_found_zero_a: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.found) |-> (rsp_data_ff.match_start == 16'd0))
      else $error("result word without a match carries a nonzero start");

   fin_hold_a: assert property (@(posedge clock) disable iff (reset)
      (fin.valid && !fin_take) |=> fin.valid)
      else $error("finished text dropped while the result register was full");

endmodule

[rtl/core/nth_substring_occurrence_search.sv]
// Channel   Direction  Handshake             Word
// req       in         req_valid/req_ready   req_data: text_byte, last_byte
// rsp       out        rsp_valid/rsp_ready   rsp_data: found, match_start
// csr       in         psel/penable/pready   paddr, pwdata, prdata (64-bit registers)
//
// One text byte is taken every cycle unless a last byte waits on a full second
// stage; the window compare, the match counters and the ring write all finish in
// the cycle a byte leaves the input register. A finished text goes on to the ring
// memory read in the second stage and the end-of-text decision in the result register.
// Synchronous reset clears all per-text state and the handshakes; the ring needs
// no clearing pass because a fill count guards it.
// A stalled result register holds the finished text in the second stage and then
// the input register, and only then drops req_ready.
module nth_substring_occurrence_search
   import nsos_pkg::*;
#(
   parameter int MAX_PATTERN    = 8,
   parameter int MAX_TEXT       = 65536,
   parameter int MAX_OCCURRENCE = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam int PW = $clog2(MAX_TEXT);

   cfg_type       cfg;
   fin_type       fin;
   logic          fin_take;
   logic [PW-1:0] fin_end;
   logic [PW-1:0] fin_pos;
   logic [PW-1:0] fin_fwd_start;
   logic [3:0]    fin_plen;

   nsos_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   nsos_scan #(
      .MAX_PATTERN    (MAX_PATTERN),
      .MAX_TEXT       (MAX_TEXT),
      .MAX_OCCURRENCE (MAX_OCCURRENCE)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .cfg           (cfg),
      .fin_take      (fin_take),
      .fin           (fin),
      .fin_end       (fin_end),
      .fin_pos       (fin_pos),
      .fin_fwd_start (fin_fwd_start),
      .fin_plen      (fin_plen)
   );

   nsos_resolve #(
      .MAX_TEXT (MAX_TEXT)
   ) u_resolve (
      .clock         (clock),
      .reset         (reset),
      .fin           (fin),
      .fin_end       (fin_end),
      .fin_pos       (fin_pos),
      .fin_fwd_start (fin_fwd_start),
      .fin_plen      (fin_plen),
      .scan_limit    (cfg.scan_limit),
      .fin_take      (fin_take),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

endmodule

[bench/tb_top.sv]
module tb_top;
   import nsos_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int RING_DEPTH  = 16;
   localparam int PATTERN_MAX = 8;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   nth_substring_occurrence_search u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // Shadow of the search state and the register settings.
   cfg_type     search_cfg;
   logic [55:0] prior_bytes;
   logic [15:0] text_pos;
   logic [4:0]  fwd_count;
   logic [15:0] fwd_start;
   logic        fwd_seen;
   logic [15:0] match_end_ring [RING_DEPTH];
   logic [3:0]  ring_wr;
   logic [4:0]  ring_fill;

   rsp_type     awaited_answers[$];
   rsp_type     oldest_answer;
   logic [7:0]  text_buf[$];

   int unsigned fail_count;
   int unsigned cycle_count;
   int unsigned burst_left;
   bit          gaps_on;
   int unsigned hold_left;
   int unsigned stall_kind;
   int unsigned stall_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic clear_text_state();
      prior_bytes = '0;
      text_pos    = '0;
      fwd_count   = '0;
      fwd_start   = '0;
      fwd_seen    = 1'b0;
      ring_wr     = '0;
      ring_fill   = '0;
   endtask

   // Advances the shadow search by one accepted word and queues the answer
   // that a marked final byte produces.
   task automatic advance_search(input req_type w);
      int          plen;
      int          s;
      int          e;
      int          total;
      logic [63:0] window;
      logic        hit;
      logic [3:0]  slot;
      rsp_type     answer;
      plen = (search_cfg.pattern_length == 0) ? 1 :
             (search_cfg.pattern_length > PATTERN_MAX) ? PATTERN_MAX :
             int'(search_cfg.pattern_length);
      window = {prior_bytes, w.text_byte};
      hit = (int'(text_pos) + 1 >= plen);
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if (k < plen) begin
            if (window[(plen - 1 - k) * 8 +: 8] != search_cfg.pattern_bytes[k * 8 +: 8])
               hit = 1'b0;
         end
      end
      if (hit) begin
         s = int'(text_pos) + 1 - plen;
         if (s < int'(search_cfg.scan_limit) && !fwd_seen) begin
            if (fwd_count != 5'd31) fwd_count = fwd_count + 5'd1;
            if (search_cfg.occurrence != 0 && search_cfg.occurrence <= RING_DEPTH &&
                fwd_count == search_cfg.occurrence) begin
               fwd_seen  = 1'b1;
               fwd_start = s[15:0];
            end
         end
         match_end_ring[ring_wr] = text_pos;
         ring_wr = ring_wr + 4'd1;
         if (ring_fill < RING_DEPTH) ring_fill = ring_fill + 5'd1;
      end
      if (!w.last_byte) begin
         prior_bytes = window[55:0];
         text_pos    = text_pos + 16'd1;
      end else begin
         answer = '0;
         if (!search_cfg.direction) begin
            if (fwd_seen) begin
               answer.found       = 1'b1;
               answer.match_start = fwd_start;
            end
         end else if (search_cfg.occurrence != 0 && search_cfg.occurrence <= RING_DEPTH &&
                      ring_fill >= search_cfg.occurrence) begin
            // The ring slot of the requested occurrence, counted back from the newest.
            slot  = ring_wr - search_cfg.occurrence[3:0];
            e     = int'(match_end_ring[slot]);
            total = int'(text_pos) + 1;
            if (e + int'(search_cfg.scan_limit) > total) begin
               answer.found       = 1'b1;
               answer.match_start = 16'(e + 1 - plen);
            end
         end
         awaited_answers.push_back(answer);
         clear_text_state();
      end
   endtask

   task automatic note_failure(input string what, input rsp_type want, input rsp_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%s: expected found=%0d start=%0d, got found=%0d start=%0d", what,
                  want.found, want.match_start, got.found, got.match_start);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_answers.size() == 0) begin
            note_failure("unexpected result word", '0, rsp_data);
         end else begin
            oldest_answer = awaited_answers.pop_front();
            if (rsp_data.found !== oldest_answer.found ||
                rsp_data.match_start !== oldest_answer.match_start)
               note_failure("result mismatch", oldest_answer, rsp_data);
         end
      end
   end

   // Receiver: a long hold-off when asked, otherwise a changing stall pattern.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_kind = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 300);
         end else begin
            stall_left = stall_left - 1;
         end
         case (stall_kind)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= ($urandom_range(0, 2) != 0);
            end
            default: begin
               rsp_ready <= (cycle_count % 7 >= 3);
            end
         endcase
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input logic [7:0] b, input logic last);
      req_type w;
      w.text_byte = b;
      w.last_byte = last;
      if (gaps_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      if (burst_left > 0) burst_left = burst_left - 1;
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      advance_search(w);
   endtask

   task automatic send_text();
      for (int i = 0; i < text_buf.size(); i++)
         send_word(text_buf[i], i == text_buf.size() - 1);
      text_buf.delete();
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_PATTERN_BYTES:  search_cfg.pattern_bytes  = value;
         REG_PATTERN_LENGTH: search_cfg.pattern_length = value[3:0];
         REG_OCCURRENCE:     search_cfg.occurrence     = value[4:0];
         REG_SCAN_LIMIT:     search_cfg.scan_limit     = value[16:0];
         default:            search_cfg.direction      = value[0];
      endcase
   endtask

   // Registers change only once every awaited word is back and the block is quiet.
   task automatic set_search(input logic [63:0] pattern, input int plen, input int occ,
                             input int limit, input bit dir);
      req_valid <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      csr_write(REG_PATTERN_BYTES, pattern);
      csr_write(REG_PATTERN_LENGTH, 64'(plen));
      csr_write(REG_OCCURRENCE, 64'(occ));
      csr_write(REG_SCAN_LIMIT, 64'(limit));
      csr_write(REG_DIRECTION, 64'(dir));
   endtask

   function automatic logic [7:0] pick_text_byte(input logic [7:0] a, input logic [7:0] b);
      if ($urandom_range(0, 99) < 85) return $urandom_range(0, 1) ? a : b;
      return 8'($urandom_range(1, 255));
   endfunction

   task automatic test_reset_values();
      // The reset pattern is a zero byte, which no text byte matches.
      text_buf = '{8'h41, 8'h42};
      send_text();
      text_buf = '{8'hFF};
      send_text();
   endtask

   task automatic test_forward_search();
      set_search(64'h6161, 2, 2, 65536, 1'b0);
      text_buf = '{8'h61, 8'h61, 8'h61, 8'h61};
      send_text();
      set_search(64'hFF01FF01FF01FF01, 8, 2, 65536, 1'b0);
      text_buf = '{8'h01, 8'hFF, 8'h01, 8'hFF, 8'h01, 8'hFF, 8'h01, 8'hFF, 8'h01, 8'hFF};
      send_text();
      set_search(64'h6161, 2, 2, 1, 1'b0);
      text_buf = '{8'h61, 8'h61, 8'h61};
      send_text();
   endtask

   task automatic test_reverse_search();
      // A limit of two reaches the last two bytes of the text.
      set_search(64'h6261, 2, 1, 2, 1'b1);
      text_buf = '{8'h61, 8'h62, 8'h61, 8'h62};
      send_text();
      set_search(64'h6261, 2, 1, 1, 1'b1);
      text_buf = '{8'h61, 8'h62};
      send_text();
      set_search(64'h6261, 2, 2, 65536, 1'b1);
      text_buf = '{8'h61, 8'h62, 8'h61, 8'h62};
      send_text();
   endtask

   task automatic test_odd_settings();
      set_search(64'h61, 1, 0, 65536, 1'b0);
      text_buf = '{8'h61, 8'h61};
      send_text();
      set_search(64'h61, 1, 17, 65536, 1'b1);
      text_buf = '{8'h61, 8'h61};
      send_text();
      set_search(64'h6261, 0, 1, 65536, 1'b0);
      text_buf = '{8'h62, 8'h61};
      send_text();
      set_search(64'h6261, 15, 1, 65536, 1'b0);
      text_buf = '{8'h61, 8'h62};
      send_text();
      set_search(64'h61, 1, 1, 0, 1'b1);
      text_buf = '{8'h61, 8'h61};
      send_text();
   endtask

   task automatic test_random_phases(input int phases, input int words_per_phase);
      logic [7:0]  a;
      logic [7:0]  b;
      logic [63:0] pattern;
      int          plen;
      int          occ;
      int          limit;
      int          sent;
      int          len;
      for (int ph = 0; ph < phases; ph++) begin
         a = 8'($urandom_range(1, 255));
         b = 8'($urandom_range(1, 255));
         for (int k = 0; k < 8; k++)
            pattern[k * 8 +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                                  ($urandom_range(0, 1) ? a : b);
         case ($urandom_range(0, 9))
            0:       plen = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 15);
            1, 2:    plen = $urandom_range(5, 8);
            default: plen = $urandom_range(1, 4);
         endcase
         case ($urandom_range(0, 9))
            0:       occ = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
            1, 2:    occ = $urandom_range(5, 16);
            default: occ = $urandom_range(1, 4);
         endcase
         case ($urandom_range(0, 5))
            0:       limit = $urandom_range(0, 1);
            1, 2:    limit = $urandom_range(2, 40);
            3:       limit = $urandom_range(0, 65536);
            default: limit = 65536;
         endcase
         set_search(pattern, plen, occ, limit, 1'($urandom_range(0, 1)));
         gaps_on = ($urandom_range(0, 9) < 7);
         sent = 0;
         while (sent < words_per_phase) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 60) : $urandom_range(1, 30);
            for (int i = 0; i < len; i++) text_buf.push_back(pick_text_byte(a, b));
            send_text();
            sent += len;
         end
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_backpressure();
      set_search(64'h6261, 2, 1, 65536, 1'b0);
      hold_left = 400;
      for (int t = 0; t < 50; t++) begin
         text_buf = '{8'h61, 8'h62, 8'($urandom_range(1, 255))};
         send_text();
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      fail_count  = 0;
      cycle_count = 0;
      burst_left  = 0;
      gaps_on     = 1'b1;
      hold_left   = 0;
      stall_kind  = 0;
      stall_left  = 0;
      search_cfg.pattern_bytes  = '0;
      search_cfg.pattern_length = 4'd1;
      search_cfg.occurrence     = 5'd1;
      search_cfg.scan_limit     = 17'd65536;
      search_cfg.direction      = 1'b0;
      clear_text_state();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_forward_search();
      test_reverse_search();
      test_odd_settings();
      test_backpressure();
      test_random_phases(12, 130);

      req_valid <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[nth_substring_occurrence_search.f]
rtl/core/nsos_pkg.sv
rtl/core/nsos_csr.sv
rtl/core/nsos_scan.sv
rtl/core/nsos_resolve.sv
rtl/core/nth_substring_occurrence_search.sv
bench/tb_top.sv
